/* rtl/core/ipv6_text_address_parser_top_macros.svh */
// Assertion macros shared by the parser RTL.
`ifndef IPV6_TEXT_ADDRESS_PARSER_TOP_MACROS_SVH
`define IPV6_TEXT_ADDRESS_PARSER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Check expr at every rising clock edge outside reset.
`define IPV6TP_ASSERT(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: expr");

// Check that cons holds in the cycle after ante.
`define IPV6TP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante |=> cons");

`else

`define IPV6TP_ASSERT(lbl, clk, rst, expr)
`define IPV6TP_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/ipv6tp_pkg.sv */
package ipv6tp_pkg;

   localparam int NUM_GROUPS = 8;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;

   localparam logic [4:0] HEX_NONE = 5'd16;

   typedef enum logic [2:0] {
      PH_FIRST  = 3'd0,
      PH_SEP    = 3'd1,
      PH_COLON  = 3'd2,
      PH_SINGLE = 3'd3,
      PH_DOUBLE = 3'd4,
      PH_OK     = 3'd5,
      PH_BAD    = 3'd6
   } phase_type;

   typedef struct packed {
      logic [NUM_GROUPS-1:0][15:0] group_store;
      logic [3:0]                  group_position;
      logic [3:0]                  gap_position;
      logic                        gap_seen;
      logic [15:0]                 group_accumulator;
      logic [2:0]                  digit_count;
      phase_type                   parse_phase;
      logic [5:0]                  char_count;
   } parse_state_type;

   // PH_FIRST encodes as zero, so an all-zero word is the reset state
   localparam parse_state_type PARSE_RESET = '0;

   typedef struct packed {
      parse_state_type st;
      logic            again;
   } pass_result_type;

   // Finished string handed from the parser to the result stage
   typedef struct packed {
      logic            valid;
      parse_state_type st;
   } final_type;

   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = HEX_NONE;
      if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
         v = 5'(c - CHAR_ZERO);
      end else if (c inside {[CHAR_LA:CHAR_LF]}) begin
         v = 5'(c - CHAR_LA) + 5'd10;
      end else if (c inside {[CHAR_UA:CHAR_UF]}) begin
         v = 5'(c - CHAR_UA) + 5'd10;
      end
      return v;
   endfunction

   function automatic parse_state_type close_group(input parse_state_type s);
      parse_state_type r;
      r = s;
      r.group_store[s.group_position[2:0]] = s.group_accumulator;
      r.group_position = s.group_position + 4'd1;
      r.group_accumulator = '0;
      r.digit_count = '0;
      r.parse_phase = (r.group_position >= 4'(NUM_GROUPS)) ? PH_OK : PH_SEP;
      return r;
   endfunction

   function automatic pass_result_type feed_pass(input parse_state_type s,
                                                 input logic [7:0] c);
      pass_result_type r;
      logic [4:0]      v;
      r.st = s;
      r.again = 1'b0;
      v = hex_value(c);
      case (s.parse_phase)
         PH_FIRST, PH_SINGLE, PH_DOUBLE: begin
            if (!v[4]) begin
               r.st.group_accumulator = {s.group_accumulator[11:0], v[3:0]};
               r.st.digit_count = s.digit_count + 3'd1;
               r.st.char_count = s.char_count + 6'd1;
               if (r.st.digit_count >= 3'd4) r.st = close_group(r.st);
            end else if (s.digit_count != 3'd0) begin
               r.st = close_group(s);
               r.again = (r.st.parse_phase == PH_SEP);
            end else if (s.parse_phase == PH_FIRST) begin
               r.st.parse_phase = PH_SEP;
               r.again = 1'b1;
            end else if (s.parse_phase == PH_SINGLE) begin
               if (s.gap_seen) begin
                  r.st.parse_phase = PH_OK;
                  r.st.char_count = s.char_count - 6'd1;
               end else begin
                  r.st.parse_phase = PH_BAD;
               end
            end else begin
               r.st.parse_phase = PH_OK;
            end
         end
         PH_SEP: begin
            if (c == CHAR_COLON) begin
               r.st.char_count = s.char_count + 6'd1;
               r.st.parse_phase = PH_COLON;
            end else begin
               r.st.parse_phase = s.gap_seen ? PH_OK : PH_BAD;
            end
         end
         PH_COLON: begin
            if (c == CHAR_COLON) begin
               if (s.gap_seen || ({1'b0, s.group_position} + 5'd2 >= 5'(NUM_GROUPS))) begin
                  r.st.parse_phase = PH_BAD;
                  r.st.char_count = s.char_count - 6'd1;
               end else begin
                  r.st.gap_position = s.group_position;
                  r.st.gap_seen = 1'b1;
                  r.st.group_position = s.group_position + 4'd2;
                  r.st.char_count = s.char_count + 6'd1;
                  r.st.group_accumulator = '0;
                  r.st.digit_count = '0;
                  r.st.parse_phase = PH_DOUBLE;
               end
            end else if (s.group_position == 4'd0) begin
               r.st.parse_phase = PH_BAD;
               r.st.char_count = s.char_count - 6'd1;
            end else begin
               r.st.parse_phase = PH_SINGLE;
               r.again = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // A character settles in at most two passes: the second pass never asks for a third
   function automatic parse_state_type feed_char(input parse_state_type s,
                                                 input logic [7:0] c);
      pass_result_type p1;
      pass_result_type p2;
      p1 = feed_pass(s, c);
      p2 = feed_pass(p1.st, c);
      return p1.again ? p2.st : p1.st;
   endfunction

endpackage

/* rtl/core/ipv6tp_req_if.sv */
interface ipv6tp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

/* rtl/core/ipv6tp_rsp_if.sv */
interface ipv6tp_rsp_if;
   logic        valid;
   logic        ready;
   logic        addr_valid;
   logic [63:0] address_high;
   logic [63:0] address_low;
   logic [5:0]  consumed_length;

   modport source (output valid, output addr_valid, output address_high,
                   output address_low, output consumed_length, input ready);
   modport sink   (input valid, input addr_valid, input address_high,
                   input address_low, input consumed_length, output ready);
endinterface

/* rtl/core/ipv6tp_parse.sv */
`include "ipv6_text_address_parser_top_macros.svh"

module ipv6tp_parse (
   input  logic                  clock,
   input  logic                  reset,
   ipv6tp_req_if.sink            req_chan,
   input  logic                  fin_ready,
   output ipv6tp_pkg::final_type fin
);

   ipv6tp_pkg::parse_state_type state_ff, state_in;
   ipv6tp_pkg::parse_state_type fed;
   ipv6tp_pkg::parse_state_type fin_state_ff;
   logic                        fin_valid_ff, fin_valid_in;
   logic                        accept;

   // hold off only while a finished string waits and cannot move on
   assign req_chan.ready = !fin_valid_ff || fin_ready;
   assign accept = req_chan.valid && req_chan.ready;

   assign fed = ipv6tp_pkg::feed_char(state_ff, req_chan.char_code);

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = req_chan.end_of_text ? ipv6tp_pkg::PARSE_RESET : fed;
      end
   end

   always_comb begin
      fin_valid_in = fin_valid_ff;
      if (accept && req_chan.end_of_text) begin
         fin_valid_in = 1'b1;
      end else if (fin_ready) begin
         fin_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ipv6tp_pkg::PARSE_RESET;
         fin_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_chan.end_of_text) begin
         fin_state_ff <= fed;
      end
   end

   assign fin.valid = fin_valid_ff;
   assign fin.st = fin_state_ff;

   `IPV6TP_ASSERT_NEXT(a_fin_hold, clock, reset, fin_valid_ff && !fin_ready, fin_valid_ff)
   `IPV6TP_ASSERT_NEXT(a_clear_after_end, clock, reset, accept && req_chan.end_of_text,
      state_ff.parse_phase == ipv6tp_pkg::PH_FIRST && state_ff.char_count == 6'd0)
   `IPV6TP_ASSERT(a_group_bound, clock, reset, state_ff.group_position <= 4'd8)
   `IPV6TP_ASSERT(a_digit_bound, clock, reset, state_ff.digit_count <= 3'd3)

endmodule

/* rtl/core/ipv6tp_expand.sv */
module ipv6tp_expand (
   input  logic                  clock,
   input  logic                  reset,
   input  ipv6tp_pkg::final_type fin,
   output logic                  fin_ready,
   ipv6tp_rsp_if.source          rsp_chan
);

   ipv6tp_pkg::parse_state_type   f;
   logic [ipv6tp_pkg::NUM_GROUPS-1:0][15:0] g;
   logic                          ok;
   logic                          expand;
   logic [3:0]                    gap;
   logic [3:0]                    first_tail;
   logic [3:0]                    tail;
   logic [2:0]                    idx;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          addr_valid_ff;
   logic [63:0]                   address_high_ff, address_low_ff;
   logic [5:0]                    consumed_length_ff;

   assign fin_ready = !rsp_valid_ff || rsp_chan.ready;

   // close the string with a terminator, then zero-fill the gap
   assign f = ipv6tp_pkg::feed_char(fin.st, ipv6tp_pkg::CHAR_NUL);
   assign ok = (f.parse_phase == ipv6tp_pkg::PH_OK);
   assign expand = f.gap_seen && (f.group_position < 4'(ipv6tp_pkg::NUM_GROUPS));
   assign gap = {1'b0, f.gap_position[2:0]};
   assign first_tail = gap + 4'd2;
   assign tail = (f.group_position > first_tail) ? f.group_position - first_tail : 4'd0;

   always_comb begin
      g = '0;
      idx = '0;
      for (int k = 0; k < ipv6tp_pkg::NUM_GROUPS; k++) begin
         idx = 3'(k) + f.group_position[2:0];
         if (!ok) begin
            g[k] = '0;
         end else if (expand) begin
            if (4'(k) < gap) begin
               g[k] = f.group_store[k];
            end else if ({1'b0, 4'(k)} + {1'b0, tail} >= 5'(ipv6tp_pkg::NUM_GROUPS)) begin
               g[k] = f.group_store[idx];
            end else begin
               g[k] = '0;
            end
         end else begin
            g[k] = f.group_store[k];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fin_ready) rsp_valid_in = fin.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_ready && fin.valid) begin
         addr_valid_ff <= ok;
         address_high_ff <= {g[0], g[1], g[2], g[3]};
         address_low_ff <= {g[4], g[5], g[6], g[7]};
         consumed_length_ff <= f.char_count;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.addr_valid = addr_valid_ff;
   assign rsp_chan.address_high = address_high_ff;
   assign rsp_chan.address_low = address_low_ff;
   assign rsp_chan.consumed_length = consumed_length_ff;

endmodule

/* rtl/core/ipv6_text_address_parser_top.sv */
// Throughput: one character request per cycle; the input stalls only while a result waits
// at the output and a second finished string waits behind it.
// A request with end_of_text set passes its result through the finished-string register,
// then through the result register behind the gap expansion.
// Characters without end_of_text give no result.
// Reset is synchronous and active high: it clears the parser state and both stage valid flags; addr_valid is not reset.
module ipv6_text_address_parser_top (
   input  logic         clock,
   input  logic         reset,
   ipv6tp_req_if.sink   req_chan,
   ipv6tp_rsp_if.source rsp_chan
);

   ipv6tp_pkg::final_type fin;
   logic                  fin_ready;

   ipv6tp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .fin_ready (fin_ready),
      .fin       (fin)
   );

   ipv6tp_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .fin       (fin),
      .fin_ready (fin_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

/* dv/ipv6_text_address_parser_top_tb.sv */
`timescale 1ns / 100ps

module ipv6_text_address_parser_top_tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_CHARS   = 1850;
   localparam int HOLD_CYCLES    = 400;

   typedef struct {
      logic        ok;
      logic [63:0] high;
      logic [63:0] low;
      logic [5:0]  length;
   } addr_result_type;

   logic clock = 1'b0;
   logic reset;

   ipv6tp_req_if req_chan();
   ipv6tp_rsp_if rsp_chan();

   ipv6_text_address_parser_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Parser image: advanced on every accepted request
   logic [15:0]           grp_words [8];
   logic [3:0]            grp_next;
   logic [3:0]            gap_at;
   logic                  gap_taken;
   logic [15:0]           grp_acc;
   logic [2:0]            grp_digits;
   ipv6tp_pkg::phase_type phase;
   logic [5:0]            consumed;

   addr_result_type pending_addrs [$];
   addr_result_type head_addr;
   logic [7:0]      text_buf [$];
   int              mismatches = 0;
   int              chars_sent = 0;
   int              quiet_cycles = 0;
   bit              sender_gaps = 1'b1;
   int              hold_request = 0;
   bit              holding = 1'b0;

   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      if (c inside {[ipv6tp_pkg::CHAR_ZERO:ipv6tp_pkg::CHAR_NINE]})
         return 5'(c - ipv6tp_pkg::CHAR_ZERO);
      if (c inside {[ipv6tp_pkg::CHAR_LA:ipv6tp_pkg::CHAR_LF]})
         return 5'(c - ipv6tp_pkg::CHAR_LA + 10);
      if (c inside {[ipv6tp_pkg::CHAR_UA:ipv6tp_pkg::CHAR_UF]})
         return 5'(c - ipv6tp_pkg::CHAR_UA + 10);
      return ipv6tp_pkg::HEX_NONE;
   endfunction

   task automatic clear_parse;
      foreach (grp_words[i]) grp_words[i] = '0;
      grp_next   = '0;
      gap_at     = '0;
      gap_taken  = 1'b0;
      grp_acc    = '0;
      grp_digits = '0;
      phase      = ipv6tp_pkg::PH_FIRST;
      consumed   = '0;
   endtask

   task automatic end_group;
      grp_words[grp_next[2:0]] = grp_acc;
      grp_next   = grp_next + 4'd1;
      grp_acc    = '0;
      grp_digits = '0;
      phase      = (grp_next >= 4'(ipv6tp_pkg::NUM_GROUPS)) ? ipv6tp_pkg::PH_OK
                                                           : ipv6tp_pkg::PH_SEP;
   endtask

   task automatic parse_char(input logic [7:0] c);
      logic [4:0] nib;
      logic       again;
      nib   = nibble_of(c);
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (phase)
            ipv6tp_pkg::PH_FIRST, ipv6tp_pkg::PH_SINGLE, ipv6tp_pkg::PH_DOUBLE: begin
               if (!nib[4]) begin
                  grp_acc    = {grp_acc[11:0], nib[3:0]};
                  grp_digits = grp_digits + 3'd1;
                  consumed   = consumed + 6'd1;
                  if (grp_digits >= 3'd4) end_group();
               end else if (grp_digits != 3'd0) begin
                  end_group();
                  again = (phase == ipv6tp_pkg::PH_SEP);
               end else if (phase == ipv6tp_pkg::PH_FIRST) begin
                  // empty first group: look at the same character as a separator
                  phase = ipv6tp_pkg::PH_SEP;
                  again = 1'b1;
               end else if (phase == ipv6tp_pkg::PH_SINGLE) begin
                  if (gap_taken) begin
                     phase    = ipv6tp_pkg::PH_OK;
                     consumed = consumed - 6'd1;
                  end else begin
                     phase = ipv6tp_pkg::PH_BAD;
                  end
               end else begin
                  phase = ipv6tp_pkg::PH_OK;
               end
            end
            ipv6tp_pkg::PH_SEP: begin
               if (c == ipv6tp_pkg::CHAR_COLON) begin
                  consumed = consumed + 6'd1;
                  phase    = ipv6tp_pkg::PH_COLON;
               end else begin
                  phase = gap_taken ? ipv6tp_pkg::PH_OK : ipv6tp_pkg::PH_BAD;
               end
            end
            ipv6tp_pkg::PH_COLON: begin
               if (c == ipv6tp_pkg::CHAR_COLON) begin
                  if (gap_taken || int'(grp_next) + 2 >= ipv6tp_pkg::NUM_GROUPS) begin
                     phase    = ipv6tp_pkg::PH_BAD;
                     consumed = consumed - 6'd1;
                  end else begin
                     gap_at     = grp_next;
                     gap_taken  = 1'b1;
                     grp_next   = grp_next + 4'd2;
                     consumed   = consumed + 6'd1;
                     grp_acc    = '0;
                     grp_digits = '0;
                     phase      = ipv6tp_pkg::PH_DOUBLE;
                  end
               end else if (grp_next == 4'd0) begin
                  phase    = ipv6tp_pkg::PH_BAD;
                  consumed = consumed - 6'd1;
               end else begin
                  phase = ipv6tp_pkg::PH_SINGLE;
                  again = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   endtask

   // Terminate the text, expand the double colon and queue the address
   task automatic close_text;
      addr_result_type r;
      logic [15:0]     w [8];
      int              gap;
      int              first_tail;
      int              tail;
      parse_char(ipv6tp_pkg::CHAR_NUL);
      r.ok = (phase == ipv6tp_pkg::PH_OK);
      foreach (w[k]) w[k] = '0;
      if (r.ok) begin
         if (gap_taken && grp_next < 4'(ipv6tp_pkg::NUM_GROUPS)) begin
            gap        = int'(gap_at[2:0]);
            first_tail = gap + 2;
            tail       = (int'(grp_next) > first_tail) ? int'(grp_next) - first_tail : 0;
            for (int k = 0; k < gap; k++) w[k] = grp_words[k];
            for (int k = 0; k < tail && k < 8; k++)
               w[(8 - tail + k) % 8] = grp_words[(first_tail + k) % 8];
         end else begin
            foreach (w[k]) w[k] = grp_words[k];
         end
      end
      r.high   = {w[0], w[1], w[2], w[3]};
      r.low    = {w[4], w[5], w[6], w[7]};
      r.length = consumed;
      pending_addrs.push_back(r);
      clear_parse();
   endtask

   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
      if (v < 4'd10) return ipv6tp_pkg::CHAR_ZERO + 8'(v);
      return (upper ? ipv6tp_pkg::CHAR_UA : ipv6tp_pkg::CHAR_LA) + 8'(v) - 8'd10;
   endfunction

   task automatic put_str(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   // Offer the buffered text, end_of_text on its last request; valid stays high after
   task automatic send_text;
      int n;
      int idle;
      n = text_buf.size();
      for (int i = 0; i < n; i++) begin
         idle = sender_gaps ? pick_idle() : 0;
         if (idle > 0) begin
            req_chan.valid <= 1'b0;
            repeat (idle) @(posedge clock);
         end
         req_chan.valid       <= 1'b1;
         req_chan.char_code   <= text_buf[i];
         req_chan.end_of_text <= (i == n - 1);
         @(posedge clock);
         while (!req_chan.ready) @(posedge clock);
         chars_sent++;
         parse_char(text_buf[i]);
         if (i == n - 1) close_text();
      end
      text_buf.delete();
   endtask

   task automatic send_str(input string s);
      put_str(s);
      send_text();
   endtask

   task automatic drop_req;
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic put_group;
      int n;
      bit upper;
      n     = ($urandom_range(0, 29) == 0) ? 5 : $urandom_range(1, 4);
      upper = 1'($urandom_range(0, 1));
      repeat (n) text_buf.push_back(hex_char(4'($urandom_range(0, 15)), upper));
   endtask

   task automatic build_address;
      int kind;
      int left;
      int right;
      int total;
      kind  = $urandom_range(0, 9);
      right = -1;
      if (kind < 3) begin
         left = 8;
      end else if (kind == 3) begin
         left = $urandom_range(1, 7);
      end else begin
         total = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 6);
         left  = $urandom_range(0, total);
         right = total - left;
      end
      for (int k = 0; k < left; k++) begin
         if (k > 0) text_buf.push_back(ipv6tp_pkg::CHAR_COLON);
         put_group();
      end
      if (right >= 0) begin
         text_buf.push_back(ipv6tp_pkg::CHAR_COLON);
         text_buf.push_back(ipv6tp_pkg::CHAR_COLON);
         for (int k = 0; k < right; k++) begin
            if (k > 0) text_buf.push_back(ipv6tp_pkg::CHAR_COLON);
            put_group();
         end
      end
   endtask

   function automatic logic [7:0] noise_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 8'($urandom_range(0, 255));
      if (r < 70) return ipv6tp_pkg::CHAR_COLON;
      return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
   endfunction

   task automatic mangle_text;
      int r;
      int pos;
      r = $urandom_range(0, 99);
      if (text_buf.size() == 0) text_buf.push_back(noise_char());
      pos = $urandom_range(0, text_buf.size() - 1);
      if (r < 65) begin
      end else if (r < 75) begin
         text_buf[pos] = noise_char();
      end else if (r < 82) begin
         text_buf.insert(pos, noise_char());
      end else if (r < 88) begin
         if (text_buf.size() > 1) text_buf.delete(pos);
      end else if (r < 94) begin
         text_buf.push_back(ipv6tp_pkg::CHAR_NUL);
         repeat ($urandom_range(1, 4)) text_buf.push_back(noise_char());
      end else begin
         repeat ($urandom_range(1, 4)) text_buf.push_back(noise_char());
      end
   endtask

   task automatic test_group_forms;
      send_str("1:2:3:4:5:6:7:8");
      send_str("FFFF:ffff:AbCd:0:0:0:0:9");
      send_str("::");
      send_str("::1");
      send_str("1::");
      send_str("fe80::1:2");
      send_str("0000:0000::");
   endtask

   task automatic test_parse_stops;
      send_str("12345");
      send_str("1:2 x");
      send_str("1::2 x");
      send_str(":1");
      send_str("1::2::3");
      send_str("1:2:3:4:5:6::7");
      send_str("1:2:");
      send_str("1::2:");
      send_str("1:2:3:4:5:6:7:8:9");
      put_str("1::2");
      text_buf.push_back(ipv6tp_pkg::CHAR_NUL);
      put_str("zz");
      send_text();
      text_buf.push_back(8'hFF);
      send_text();
      text_buf.push_back(ipv6tp_pkg::CHAR_NUL);
      send_text();
      send_str("g");
   endtask

   // Stall the result side for a long stretch while short texts keep coming
   task automatic test_backpressure_fill;
      sender_gaps  = 1'b0;
      hold_request = HOLD_CYCLES;
      while (!holding && hold_request != 0) send_str("1::");
      for (int k = 0; k < 40; k++) begin
         if (k % 2 == 0) send_str("::");
         else send_str("a");
      end
      sender_gaps = 1'b1;
   endtask

   task automatic test_random_addresses;
      while (chars_sent < RANDOM_CHARS) begin
         sender_gaps = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) text_buf.push_back(noise_char());
         end else begin
            build_address();
            mangle_text();
         end
         send_text();
      end
      sender_gaps = 1'b1;
   endtask

   initial begin
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.char_code   <= '0;
      req_chan.end_of_text <= 1'b0;
      clear_parse();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_group_forms();
      test_parse_stops();
      test_backpressure_fill();
      test_random_addresses();

      drop_req();
      while (pending_addrs.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("ipv6_text_address_parser_top verification clean");
      end else begin
         $display("ipv6_text_address_parser_top verification failed");
      end
      $finish;
   end

   // Result side: ready in random stretches, with a long hold when asked
   initial begin
      int span;
      int idle;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         span = $urandom_range(1, 40);
         rsp_chan.ready <= 1'b1;
         repeat (span) @(posedge clock);
         if (hold_request > 0) begin
            rsp_chan.ready <= 1'b0;
            holding = 1'b1;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
            holding      = 1'b0;
         end else begin
            idle = pick_idle();
            if (idle > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (idle) @(posedge clock);
            end
         end
      end
   end

   function automatic void check_field(input string what, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_addrs.size() == 0) begin
            $display("%0t: result with no request pending: expected none, actual %b %h %h %0d",
                     $time, rsp_chan.addr_valid, rsp_chan.address_high,
                     rsp_chan.address_low, rsp_chan.consumed_length);
            mismatches++;
         end else begin
            head_addr = pending_addrs.pop_front();
            check_field("addr_valid", 64'(head_addr.ok), 64'(rsp_chan.addr_valid));
            check_field("address_high", head_addr.high, rsp_chan.address_high);
            check_field("address_low", head_addr.low, rsp_chan.address_low);
            check_field("consumed_length", 64'(head_addr.length),
                        64'(rsp_chan.consumed_length));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("ipv6_text_address_parser_top verification failed");
         $finish;
      end
   end

endmodule
